// ----- rtl/hvs_pkg.sv -----
// ============================================================================
// hvs_pkg
// Shared types, constants and codes for the heating valve supervisor.
// ============================================================================
`default_nettype none

package hvs_pkg;

    localparam int TEMP_BITS = 12;
    localparam int TIME_BITS = 32;

    // Threshold registers are unsigned; compares run in a signed word that
    // holds a threshold plus five degrees and every temperature reading.
    localparam int THR_BITS = 11;
    localparam int TMO_BITS = 16;
    localparam int CMP_BITS = ((TEMP_BITS > THR_BITS + 1) ? TEMP_BITS : THR_BITS + 1) + 2;

    localparam int IN_FIELD_BITS  = 1 + TEMP_BITS;
    localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 + 1 + 1 + 1 + TEMP_BITS + 1;
    localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef logic signed [TEMP_BITS-1:0] temp_t;
    typedef logic signed [CMP_BITS-1:0]  cmp_t;
    typedef logic [TIME_BITS-1:0]        tick_t;
    typedef logic [THR_BITS-1:0]         thr_t;
    typedef logic [TMO_BITS-1:0]         tmo_t;
    typedef logic [IN_DATA_W-1:0]        in_data_t;
    typedef logic [OUT_DATA_W-1:0]       out_data_t;
    typedef logic [APB_DATA_W-1:0]       apb_data_t;

    // Temperatures in 1/16 C
    localparam cmp_t HALF_DEG    = cmp_t'(8);
    localparam cmp_t TWO_DEG     = cmp_t'(32);
    localparam cmp_t FIVE_DEG    = cmp_t'(80);
    localparam cmp_t LOW_ACCEPT  = cmp_t'(640);
    localparam cmp_t HIGH_ACCEPT = cmp_t'(1920);

    localparam thr_t RST_OPERATING_TEMP    = thr_t'(1280);
    localparam thr_t RST_COOLDOWN_TEMP     = thr_t'(800);
    localparam tmo_t RST_HEATUP_TIMEOUT    = tmo_t'(600);
    localparam tmo_t RST_COOLDOWN_TIMEOUT  = tmo_t'(600);
    localparam tmo_t RST_HEARTBEAT_TIMEOUT = tmo_t'(300);

    typedef enum logic [2:0] {
        REG_OPERATING_TEMP    = 3'd0,
        REG_COOLDOWN_TEMP     = 3'd1,
        REG_HEATUP_TIMEOUT    = 3'd2,
        REG_COOLDOWN_TIMEOUT  = 3'd3,
        REG_HEARTBEAT_TIMEOUT = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_BEAT = 2'd2,
        CMD_TEMP = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OFF            = 3'd0,
        ST_OPENING        = 3'd1,
        ST_WARMUP         = 3'd2,
        ST_ON             = 3'd3,
        ST_CLOSING        = 3'd4,
        ST_COOLDOWN       = 3'd5,
        ST_STARTUP_FAULT  = 3'd6,
        ST_SHUTDOWN_FAULT = 3'd7
    } valve_state_t;

    typedef struct packed {
        thr_t operating_temp;
        thr_t cooldown_temp;
        tmo_t heatup_timeout;
        tmo_t cooldown_timeout;
        tmo_t heartbeat_timeout;
    } cfg_t;

    typedef struct packed {
        cmd_t  command;
        logic  on_value;
        temp_t temperature;
    } item_t;

    typedef struct packed {
        valve_state_t valve_state;
        logic         is_on;
        logic         relay_drive_n;
        logic         heartbeat_fault;
        temp_t        current_temp;
        logic         report_now;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/hvs_cfg_regs.sv -----
// ============================================================================
// hvs_cfg_regs
// APB register file holding thresholds and timeouts.
// ============================================================================
`default_nettype none

module hvs_cfg_regs
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hvs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire hvs_pkg::apb_data_t             pwdata,
    output hvs_pkg::apb_data_t                  prdata,
    output logic                                pready,
    output hvs_pkg::cfg_t                       cfg
);

    hvs_pkg::cfg_t     cfg_reg;
    hvs_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = hvs_pkg::reg_idx_t'(paddr[hvs_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.operating_temp    <= hvs_pkg::RST_OPERATING_TEMP;
            cfg_reg.cooldown_temp     <= hvs_pkg::RST_COOLDOWN_TEMP;
            cfg_reg.heatup_timeout    <= hvs_pkg::RST_HEATUP_TIMEOUT;
            cfg_reg.cooldown_timeout  <= hvs_pkg::RST_COOLDOWN_TIMEOUT;
            cfg_reg.heartbeat_timeout <= hvs_pkg::RST_HEARTBEAT_TIMEOUT;
        end
        else if (wr_en)
        begin
            case (idx)
                hvs_pkg::REG_OPERATING_TEMP:
                    cfg_reg.operating_temp <= pwdata[hvs_pkg::THR_BITS-1:0];
                hvs_pkg::REG_COOLDOWN_TEMP:
                    cfg_reg.cooldown_temp <= pwdata[hvs_pkg::THR_BITS-1:0];
                hvs_pkg::REG_HEATUP_TIMEOUT:
                    cfg_reg.heatup_timeout <= pwdata[hvs_pkg::TMO_BITS-1:0];
                hvs_pkg::REG_COOLDOWN_TIMEOUT:
                    cfg_reg.cooldown_timeout <= pwdata[hvs_pkg::TMO_BITS-1:0];
                hvs_pkg::REG_HEARTBEAT_TIMEOUT:
                    cfg_reg.heartbeat_timeout <= pwdata[hvs_pkg::TMO_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            hvs_pkg::REG_OPERATING_TEMP:
                prdata = hvs_pkg::apb_data_t'(cfg_reg.operating_temp);
            hvs_pkg::REG_COOLDOWN_TEMP:
                prdata = hvs_pkg::apb_data_t'(cfg_reg.cooldown_temp);
            hvs_pkg::REG_HEATUP_TIMEOUT:
                prdata = hvs_pkg::apb_data_t'(cfg_reg.heatup_timeout);
            hvs_pkg::REG_COOLDOWN_TIMEOUT:
                prdata = hvs_pkg::apb_data_t'(cfg_reg.cooldown_timeout);
            hvs_pkg::REG_HEARTBEAT_TIMEOUT:
                prdata = hvs_pkg::apb_data_t'(cfg_reg.heartbeat_timeout);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/hvs_core.sv -----
// ============================================================================
// hvs_core
// Supervisor state and the one-pass update for a single event beat.
// ============================================================================
`default_nettype none

module hvs_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire hvs_pkg::item_t   item,
    input  wire hvs_pkg::cfg_t    cfg,
    output hvs_pkg::result_t      res
);

    hvs_pkg::valve_state_t state_reg, state_next;
    logic                  on_flag_reg, on_flag_next;
    hvs_pkg::temp_t        temp_now_reg, temp_now_next;
    hvs_pkg::temp_t        temp_prev_reg, temp_prev_next;
    hvs_pkg::temp_t        startup_temp_reg, startup_temp_next;
    hvs_pkg::temp_t        shutdown_temp_reg, shutdown_temp_next;
    logic                  temp_seen_reg, temp_seen_next;
    logic                  prev_ok_reg, prev_ok_next;
    logic                  start_ok_reg, start_ok_next;
    logic                  shut_ok_reg, shut_ok_next;
    hvs_pkg::tick_t        warm_start_reg, warm_start_next;
    hvs_pkg::tick_t        cool_start_reg, cool_start_next;
    hvs_pkg::tick_t        beat_time_reg, beat_time_next;
    hvs_pkg::tick_t        tick_reg, tick_next;
    logic                  beat_seen_reg, beat_seen_next;
    logic                  beat_expired_reg, beat_expired_next;

    hvs_pkg::tick_t        tick_inc;
    hvs_pkg::cmp_t         t, tp, t_su, t_sd, t_in, op, cd;
    logic                  tv;
    logic                  wd_trip, cool_trip, warm_trip;
    logic                  cool_stamp, warm_stamp;
    logic                  report;
    hvs_pkg::valve_state_t st1;
    logic                  on1;

    assign tick_inc = tick_reg + hvs_pkg::tick_t'(1);
    assign t        = hvs_pkg::cmp_t'(temp_now_reg);
    assign tp       = hvs_pkg::cmp_t'(temp_prev_reg);
    assign t_su     = hvs_pkg::cmp_t'(startup_temp_reg);
    assign t_in     = hvs_pkg::cmp_t'(item.temperature);
    assign op       = hvs_pkg::cmp_t'(cfg.operating_temp);
    assign cd       = hvs_pkg::cmp_t'(cfg.cooldown_temp);
    assign tv       = temp_seen_reg;

    // Watchdog only counts once a heartbeat time is stamped; the first
    // on-tick stamps it, so elapsed is zero then.
    assign wd_trip   = on_flag_reg && beat_seen_reg
                       && ((tick_inc - beat_time_reg)
                           > hvs_pkg::tick_t'(cfg.heartbeat_timeout));
    assign warm_trip = (tick_inc - warm_start_reg)
                       > hvs_pkg::tick_t'(cfg.heatup_timeout);

    always_comb
    begin
        state_next         = state_reg;
        on_flag_next       = on_flag_reg;
        temp_now_next      = temp_now_reg;
        temp_prev_next     = temp_prev_reg;
        startup_temp_next  = startup_temp_reg;
        shutdown_temp_next = shutdown_temp_reg;
        temp_seen_next     = temp_seen_reg;
        prev_ok_next       = prev_ok_reg;
        start_ok_next      = start_ok_reg;
        shut_ok_next       = shut_ok_reg;
        warm_start_next    = warm_start_reg;
        cool_start_next    = cool_start_reg;
        beat_time_next     = beat_time_reg;
        tick_next          = tick_reg;
        beat_seen_next     = beat_seen_reg;
        beat_expired_next  = beat_expired_reg;
        report             = 1'b0;
        st1                = state_reg;
        on1                = on_flag_reg;
        cool_stamp         = 1'b0;
        warm_stamp         = 1'b0;
        cool_trip          = 1'b0;
        t_sd               = hvs_pkg::cmp_t'(shutdown_temp_reg);

        case (item.command)
            hvs_pkg::CMD_TICK:
            begin
                tick_next = tick_inc;
                if (on_flag_reg && !beat_seen_reg)
                begin
                    beat_time_next = tick_inc;
                    beat_seen_next = 1'b1;
                end
                // forced off by the watchdog
                if (wd_trip)
                begin
                    on1               = 1'b0;
                    beat_expired_next = 1'b1;
                    report            = 1'b1;
                    case (state_reg)
                        hvs_pkg::ST_ON, hvs_pkg::ST_OPENING, hvs_pkg::ST_WARMUP:
                        begin
                            st1                = hvs_pkg::ST_CLOSING;
                            shutdown_temp_next = temp_now_reg;
                            shut_ok_next       = temp_seen_reg;
                            t_sd               = t;
                            cool_stamp         = 1'b1;
                        end
                        hvs_pkg::ST_STARTUP_FAULT, hvs_pkg::ST_SHUTDOWN_FAULT:
                        begin
                            st1        = hvs_pkg::ST_CLOSING;
                            cool_stamp = 1'b1;
                        end
                        default:
                            ;
                    endcase
                end
                cool_trip = !cool_stamp
                            && ((tick_inc - cool_start_reg)
                                > hvs_pkg::tick_t'(cfg.cooldown_timeout));

                state_next = st1;
                case (st1)
                    hvs_pkg::ST_CLOSING:
                    begin
                        if (tv && shut_ok_next && t < t_sd - hvs_pkg::HALF_DEG)
                            state_next = hvs_pkg::ST_COOLDOWN;
                        if (tv && t <= cd)
                            state_next = hvs_pkg::ST_OFF;
                        if (cool_trip)
                            state_next = hvs_pkg::ST_SHUTDOWN_FAULT;
                    end
                    hvs_pkg::ST_COOLDOWN:
                    begin
                        if (tv && t <= cd)
                            state_next = hvs_pkg::ST_OFF;
                        if (tv && prev_ok_reg && t < tp)
                            cool_stamp = 1'b1;
                        if (cool_trip && !cool_stamp)
                            state_next = hvs_pkg::ST_SHUTDOWN_FAULT;
                    end
                    hvs_pkg::ST_OFF:
                    begin
                        if (tv && t > cd + hvs_pkg::FIVE_DEG && !on1)
                            state_next = hvs_pkg::ST_SHUTDOWN_FAULT;
                        if (on1)
                            state_next = hvs_pkg::ST_WARMUP;
                    end
                    hvs_pkg::ST_OPENING:
                    begin
                        if (tv && start_ok_reg && t > t_su + hvs_pkg::HALF_DEG)
                            state_next = hvs_pkg::ST_WARMUP;
                        if (tv && t >= op)
                            state_next = hvs_pkg::ST_ON;
                        if (warm_trip)
                            state_next = hvs_pkg::ST_STARTUP_FAULT;
                    end
                    hvs_pkg::ST_WARMUP:
                    begin
                        if (tv && t >= op)
                            state_next = hvs_pkg::ST_ON;
                        if (tv && prev_ok_reg && t > tp)
                            warm_stamp = 1'b1;
                        if (tv && start_ok_reg && t < t_su - hvs_pkg::TWO_DEG)
                            state_next = hvs_pkg::ST_STARTUP_FAULT;
                        if (warm_trip && !warm_stamp)
                            state_next = hvs_pkg::ST_STARTUP_FAULT;
                    end
                    hvs_pkg::ST_ON:
                    begin
                        if (tv && t < op - hvs_pkg::FIVE_DEG && on1)
                            state_next = hvs_pkg::ST_STARTUP_FAULT;
                        if (!on1)
                            state_next = hvs_pkg::ST_COOLDOWN;
                    end
                    hvs_pkg::ST_STARTUP_FAULT:
                    begin
                        if (tv && t > op)
                            state_next = hvs_pkg::ST_ON;
                        if (!on1)
                            state_next = hvs_pkg::ST_OFF;
                    end
                    default:
                    begin
                        if (tv && t < cd)
                            state_next = hvs_pkg::ST_OFF;
                        if (on1)
                            state_next = hvs_pkg::ST_ON;
                    end
                endcase

                on_flag_next = on1;
                if (cool_stamp)
                    cool_start_next = tick_inc;
                if (warm_stamp)
                    warm_start_next = tick_inc;
            end

            hvs_pkg::CMD_SET:
            begin
                report       = 1'b1;
                on_flag_next = item.on_value;
                case (state_reg)
                    hvs_pkg::ST_OFF, hvs_pkg::ST_CLOSING, hvs_pkg::ST_COOLDOWN:
                    begin
                        if (item.on_value)
                        begin
                            state_next        = hvs_pkg::ST_OPENING;
                            startup_temp_next = temp_now_reg;
                            start_ok_next     = temp_seen_reg;
                            warm_start_next   = tick_reg;
                        end
                    end
                    hvs_pkg::ST_ON, hvs_pkg::ST_OPENING, hvs_pkg::ST_WARMUP:
                    begin
                        if (!item.on_value)
                        begin
                            state_next         = hvs_pkg::ST_CLOSING;
                            shutdown_temp_next = temp_now_reg;
                            shut_ok_next       = temp_seen_reg;
                            cool_start_next    = tick_reg;
                        end
                    end
                    default:
                    begin
                        // fault recovery keeps the old snapshot
                        if (item.on_value)
                        begin
                            state_next      = hvs_pkg::ST_OPENING;
                            warm_start_next = tick_reg;
                        end
                        else
                        begin
                            state_next      = hvs_pkg::ST_CLOSING;
                            cool_start_next = tick_reg;
                        end
                    end
                endcase
            end

            hvs_pkg::CMD_BEAT:
            begin
                beat_time_next = tick_reg;
                beat_seen_next = 1'b1;
            end

            default:
            begin
                temp_prev_next = temp_now_reg;
                prev_ok_next   = temp_seen_reg;
                if (!temp_seen_reg)
                begin
                    temp_now_next  = item.temperature;
                    temp_seen_next = 1'b1;
                end
                else if (t_in > hvs_pkg::LOW_ACCEPT && t_in < hvs_pkg::HIGH_ACCEPT)
                begin
                    temp_now_next = item.temperature;
                end
            end
        endcase

        res.valve_state     = state_next;
        res.is_on           = on_flag_next;
        res.relay_drive_n   = !on_flag_next;
        res.heartbeat_fault = beat_expired_next;
        res.current_temp    = temp_seen_next ? temp_now_next : '0;
        res.report_now      = report;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= hvs_pkg::ST_OFF;
            on_flag_reg       <= 1'b0;
            temp_now_reg      <= '0;
            temp_prev_reg     <= '0;
            startup_temp_reg  <= '0;
            shutdown_temp_reg <= '0;
            temp_seen_reg     <= 1'b0;
            prev_ok_reg       <= 1'b0;
            start_ok_reg      <= 1'b0;
            shut_ok_reg       <= 1'b0;
            warm_start_reg    <= '0;
            cool_start_reg    <= '0;
            beat_time_reg     <= '0;
            tick_reg          <= '0;
            beat_seen_reg     <= 1'b0;
            beat_expired_reg  <= 1'b0;
        end
        else if (en)
        begin
            state_reg         <= state_next;
            on_flag_reg       <= on_flag_next;
            temp_now_reg      <= temp_now_next;
            temp_prev_reg     <= temp_prev_next;
            startup_temp_reg  <= startup_temp_next;
            shutdown_temp_reg <= shutdown_temp_next;
            temp_seen_reg     <= temp_seen_next;
            prev_ok_reg       <= prev_ok_next;
            start_ok_reg      <= start_ok_next;
            shut_ok_reg       <= shut_ok_next;
            warm_start_reg    <= warm_start_next;
            cool_start_reg    <= cool_start_next;
            beat_time_reg     <= beat_time_next;
            tick_reg          <= tick_next;
            beat_seen_reg     <= beat_seen_next;
            beat_expired_reg  <= beat_expired_next;
        end
    end

    // watchdog fault is sticky until reset
    a_expired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        beat_expired_reg |=> beat_expired_reg)
        else $error("heartbeat fault cleared");

    // a watchdog expiry always leaves the valve commanded off
    a_expired_off: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(beat_expired_reg) |-> !on_flag_reg)
        else $error("watchdog expiry left valve on");

    // once a reading was taken, a reading stays valid
    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        temp_seen_reg |=> temp_seen_reg)
        else $error("temperature valid dropped");

    // the previous reading cannot be valid before any reading
    a_prev_ok: assert property (@(posedge clk) disable iff (!rst_n)
        prev_ok_reg |-> temp_seen_reg)
        else $error("previous reading valid without a reading");

endmodule

`default_nettype wire

// ----- rtl/heating_valve_supervisor.sv -----
// ============================================================================
// heating_valve_supervisor
// Heating valve supervisor: event stream in, one status beat out per event.
// ============================================================================
//
//  channel   dir   handshake              contents
//  s_axis    in    tvalid/tready          tuser: command; tdata: on_value, temperature
//  m_axis    out   tvalid/tready          tdata: valve state, on flags, fault, temp, report
//  apb       in    psel/penable/pready    thresholds and timeouts, 5 words at 4*i
//
//  One event beat per cycle sustained while m_axis is ready; each event passes
//  the input register, then the result register, before its status beat is offered.
//  The state update for an event is a single pass from the input register.
//  A stalled m_axis holds its beat; one more event waits in the input
//  register before s_axis_tready drops.
//  rst_n clears all supervisor state and restores register defaults.
// ============================================================================
`default_nettype none

module heating_valve_supervisor
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire hvs_pkg::in_data_t              s_axis_tdata,   // on_value, temperature
    input  wire logic [1:0]                     s_axis_tuser,   // command

    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // valve_state, is_on, relay_drive_n, heartbeat_fault, current_temp, report_now
    output hvs_pkg::out_data_t                  m_axis_tdata,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hvs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire hvs_pkg::apb_data_t             pwdata,
    output hvs_pkg::apb_data_t                  prdata,
    output logic                                pready
);

    hvs_pkg::cfg_t    cfg;
    hvs_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    hvs_pkg::result_t res;
    hvs_pkg::result_t out_res_reg;
    logic             out_valid_reg;
    logic             advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    hvs_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hvs_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.command     <= hvs_pkg::cmd_t'(s_axis_tuser);
            in_item_reg.on_value    <= s_axis_tdata[0];
            in_item_reg.temperature <= s_axis_tdata[hvs_pkg::TEMP_BITS:1];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = hvs_pkg::out_data_t'({out_res_reg.report_now,
                                                 out_res_reg.current_temp,
                                                 out_res_reg.heartbeat_fault,
                                                 out_res_reg.relay_drive_n,
                                                 out_res_reg.is_on,
                                                 out_res_reg.valve_state});

endmodule

`default_nettype wire
